>>> hdl/hba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hba_pkg
// Shared types and codes for the handle bump allocator.
// ----------------------------------------------------------------------------
package hba_pkg;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_DEALLOC = 2'd1;
    localparam logic [1:0] OP_FIND    = 2'd2;
    localparam logic [1:0] OP_SIZE    = 2'd3;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_UNKNOWN    = 2'd1;
    localparam logic [1:0] STATUS_TABLE_FULL = 2'd2;
    localparam logic [1:0] STATUS_HEAP_FULL  = 2'd3;

    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_HEAP_LIMIT = 1'b1;

    localparam int ALU_W = 35;

    typedef struct packed {
        logic range_we;
        logic valid_we;
        logic valid_bit;
        logic rd_en;
    } tbl_ctl_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] start;
        logic [31:0] stop;
    } entry_t;

endpackage

>>> hdl/hba_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hba_alu
// Shared add/subtract unit; sign of the result serves as the compare flag.
// ----------------------------------------------------------------------------
module hba_alu (
    input  logic [hba_pkg::ALU_W-1:0] a,
    input  logic [hba_pkg::ALU_W-1:0] b,
    input  logic                      sub,
    output logic [hba_pkg::ALU_W-1:0] sum
);

    logic [hba_pkg::ALU_W-1:0] b_op;

    assign b_op = sub ? ~b : b;
    assign sum  = a + b_op + hba_pkg::ALU_W'(sub);

endmodule

>>> hdl/hba_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hba_table
// Handle table storage: valid marks and block ranges, registered read.
// ----------------------------------------------------------------------------
module hba_table #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic               clk,
    input  hba_pkg::tbl_ctl_t  ctl,
    input  logic [IDX_W-1:0]   wr_addr,
    input  logic [31:0]        wr_start,
    input  logic [31:0]        wr_stop,
    input  logic [IDX_W-1:0]   rd_addr,
    output hba_pkg::entry_t    rd_data
);

    logic        valid_mem [DEPTH];
    logic [31:0] start_mem [DEPTH];
    logic [31:0] stop_mem  [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.valid_we)
        begin
            valid_mem[wr_addr] <= ctl.valid_bit;
        end
        if (ctl.range_we)
        begin
            start_mem[wr_addr] <= wr_start;
            stop_mem[wr_addr]  <= wr_stop;
        end
        if (ctl.rd_en)
        begin
            rd_data.valid <= valid_mem[rd_addr];
            rd_data.start <= start_mem[rd_addr];
            rd_data.stop  <= stop_mem[rd_addr];
        end
    end

endmodule

>>> hdl/handle_bump_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handle_bump_allocator
// Bump allocator with a handle table, run by a small sequencer around one
// shared 35-bit add/subtract unit.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the result is produced. The result appears for one cycle with done
// high and must be captured then, as there is no way to hold it. Allocate
// steps through base, top, limit check, handle write and bump (ending at base
// on a full table, at the limit check on a full heap); deallocate and size
// query step through difference, decode check and table use (ending at the
// decode check when the handle does not decode). A containment lookup walks the
// table one entry at a time through the shared unit and the table read port,
// then closes a miss or forms the handle on a hit. The table needs no clearing
// after reset; entries beyond the issued count are never read. Configuration
// writes are always ready and must only be made while busy is low.
// ----------------------------------------------------------------------------
module handle_bump_allocator #(
    parameter int MAX_HANDLES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [31:0] req_size,
    input  logic [31:0] req_handle,
    input  logic [31:0] query_address,
    output logic        done,
    output logic [31:0] handle_result,
    output logic [31:0] size_result,
    output logic [1:0]  status,
    output logic        mem_write_valid,
    output logic [31:0] mem_write_addr,
    output logic [31:0] mem_write_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int IDX_W = (MAX_HANDLES > 1) ? $clog2(MAX_HANDLES) : 1;
    localparam int CNT_W = $clog2(MAX_HANDLES + 1);
    localparam int AW    = hba_pkg::ALU_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_A_BASE = 4'd1;
    localparam logic [3:0] ST_A_TOP  = 4'd2;
    localparam logic [3:0] ST_A_LIM  = 4'd3;
    localparam logic [3:0] ST_A_HDL  = 4'd4;
    localparam logic [3:0] ST_A_BUMP = 4'd5;
    localparam logic [3:0] ST_D_DIFF = 4'd6;
    localparam logic [3:0] ST_D_CHK  = 4'd7;
    localparam logic [3:0] ST_D_USE  = 4'd8;
    localparam logic [3:0] ST_F_RD   = 4'd9;
    localparam logic [3:0] ST_F_GE   = 4'd10;
    localparam logic [3:0] ST_F_LT   = 4'd11;
    localparam logic [3:0] ST_F_HDL  = 4'd12;

    logic [3:0]       state_reg, state_next;
    logic [31:0]      base_reg, limit_reg;
    logic [31:0]      bump_reg, bump_next;
    logic [CNT_W-1:0] issued_reg, issued_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             ge_reg, ge_next;
    logic [1:0]       op_reg;
    logic [31:0]      size_reg, handle_reg, query_reg;
    logic [AW-1:0]    acc_reg, acc_next;
    logic [AW-1:0]    top_reg, top_next;
    logic [31:0]      hdl_reg, hdl_next;

    logic             done_reg;
    logic [31:0]      hres_reg, sres_reg, waddr_reg, wdata_reg;
    logic [1:0]       status_reg;
    logic             wvalid_reg;

    logic             fin;
    logic [31:0]      fin_handle, fin_size, fin_waddr, fin_wdata;
    logic [1:0]       fin_status;
    logic             fin_wvalid;

    logic [AW-1:0]    alu_a, alu_b, alu_sum;
    logic             alu_sub;

    hba_pkg::tbl_ctl_t tbl_ctl;
    hba_pkg::entry_t   rd_data;
    logic [IDX_W-1:0]  tbl_wr_addr, tbl_rd_addr;

    logic             accept;
    logic             decode_ok;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign decode_ok = (acc_reg[1:0] == 2'b00) && (30'(issued_reg) > acc_reg[31:2]);

    hba_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum)
    );

    hba_table #(
        .DEPTH (MAX_HANDLES),
        .IDX_W (IDX_W)
    ) u_table (
        .clk      (clk),
        .ctl      (tbl_ctl),
        .wr_addr  (tbl_wr_addr),
        .wr_start (acc_reg[31:0]),
        .wr_stop  (top_reg[31:0]),
        .rd_addr  (tbl_rd_addr),
        .rd_data  (rd_data)
    );

    always_comb
    begin
        state_next  = state_reg;
        bump_next   = bump_reg;
        issued_next = issued_reg;
        idx_next    = idx_reg;
        ge_next     = ge_reg;
        acc_next    = acc_reg;
        top_next    = top_reg;
        hdl_next    = hdl_reg;
        alu_a       = '0;
        alu_b       = '0;
        alu_sub     = 1'b0;
        tbl_ctl     = '0;
        tbl_wr_addr = idx_reg[IDX_W-1:0];
        tbl_rd_addr = idx_reg[IDX_W-1:0];
        fin         = 1'b0;
        fin_handle  = '0;
        fin_size    = '0;
        fin_status  = hba_pkg::STATUS_OK;
        fin_wvalid  = 1'b0;
        fin_waddr   = '0;
        fin_wdata   = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    idx_next = '0;
                    unique case (op)
                        hba_pkg::OP_ALLOC:   state_next = ST_A_BASE;
                        hba_pkg::OP_DEALLOC: state_next = ST_D_DIFF;
                        hba_pkg::OP_FIND:    state_next = ST_F_RD;
                        hba_pkg::OP_SIZE:    state_next = ST_D_DIFF;
                        default:             state_next = ST_IDLE;
                    endcase
                end
            end
            ST_A_BASE:
            begin
                alu_a    = AW'(base_reg);
                alu_b    = AW'(bump_reg);
                acc_next = alu_sum;
                if (issued_reg == CNT_W'(MAX_HANDLES))
                begin
                    fin        = 1'b1;
                    fin_status = hba_pkg::STATUS_TABLE_FULL;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_A_TOP;
                end
            end
            ST_A_TOP:
            begin
                alu_a      = acc_reg;
                alu_b      = AW'(size_reg);
                top_next   = alu_sum;
                state_next = ST_A_LIM;
            end
            ST_A_LIM:
            begin
                alu_a   = AW'(limit_reg);
                alu_b   = top_reg;
                alu_sub = 1'b1;
                if (alu_sum[AW-1])
                begin
                    fin        = 1'b1;
                    fin_status = hba_pkg::STATUS_HEAP_FULL;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_A_HDL;
                end
            end
            ST_A_HDL:
            begin
                alu_a              = AW'(base_reg);
                alu_b              = AW'({issued_reg, 2'b00});
                hdl_next           = alu_sum[31:0];
                tbl_wr_addr        = issued_reg[IDX_W-1:0];
                tbl_ctl.range_we   = 1'b1;
                tbl_ctl.valid_we   = 1'b1;
                tbl_ctl.valid_bit  = 1'b1;
                state_next         = ST_A_BUMP;
            end
            ST_A_BUMP:
            begin
                alu_a       = AW'(bump_reg);
                alu_b       = AW'(size_reg);
                bump_next   = alu_sum[31:0];
                issued_next = issued_reg + CNT_W'(1);
                fin         = 1'b1;
                fin_handle  = hdl_reg;
                fin_wvalid  = 1'b1;
                fin_waddr   = hdl_reg;
                fin_wdata   = acc_reg[31:0];
                state_next  = ST_IDLE;
            end
            ST_D_DIFF:
            begin
                alu_a      = AW'(handle_reg);
                alu_b      = AW'(base_reg);
                alu_sub    = 1'b1;
                acc_next   = alu_sum;
                state_next = ST_D_CHK;
            end
            ST_D_CHK:
            begin
                tbl_rd_addr = acc_reg[IDX_W+1:2];
                idx_next    = CNT_W'(acc_reg[IDX_W+1:2]);
                if (decode_ok)
                begin
                    tbl_ctl.rd_en = 1'b1;
                    state_next    = ST_D_USE;
                end
                else
                begin
                    fin        = 1'b1;
                    fin_status = hba_pkg::STATUS_UNKNOWN;
                    state_next = ST_IDLE;
                end
            end
            ST_D_USE:
            begin
                alu_a      = AW'(rd_data.stop);
                alu_b      = AW'(rd_data.start);
                alu_sub    = 1'b1;
                fin        = 1'b1;
                state_next = ST_IDLE;
                if (!rd_data.valid)
                begin
                    fin_status = hba_pkg::STATUS_UNKNOWN;
                end
                else if (op_reg == hba_pkg::OP_DEALLOC)
                begin
                    tbl_ctl.valid_we  = 1'b1;
                    tbl_ctl.valid_bit = 1'b0;
                end
                else
                begin
                    fin_size = alu_sum[31:0];
                end
            end
            ST_F_RD:
            begin
                if (idx_reg == issued_reg)
                begin
                    fin        = 1'b1;
                    fin_status = hba_pkg::STATUS_UNKNOWN;
                    state_next = ST_IDLE;
                end
                else
                begin
                    tbl_ctl.rd_en = 1'b1;
                    state_next    = ST_F_GE;
                end
            end
            ST_F_GE:
            begin
                alu_a      = AW'(query_reg);
                alu_b      = AW'(rd_data.start);
                alu_sub    = 1'b1;
                ge_next    = !alu_sum[AW-1];
                state_next = ST_F_LT;
            end
            ST_F_LT:
            begin
                alu_a   = AW'(query_reg);
                alu_b   = AW'(rd_data.stop);
                alu_sub = 1'b1;
                if (rd_data.valid && ge_reg && alu_sum[AW-1])
                begin
                    state_next = ST_F_HDL;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_F_RD;
                end
            end
            ST_F_HDL:
            begin
                alu_a      = AW'(base_reg);
                alu_b      = AW'({idx_reg, 2'b00});
                fin        = 1'b1;
                fin_handle = alu_sum[31:0];
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            base_reg   <= '0;
            limit_reg  <= '1;
            bump_reg   <= '0;
            issued_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            bump_reg   <= bump_next;
            issued_reg <= issued_next;
            done_reg   <= fin;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    hba_pkg::CFG_HEAP_BASE:  base_reg  <= cfg_data;
                    hba_pkg::CFG_HEAP_LIMIT: limit_reg <= cfg_data;
                    default:                 base_reg  <= base_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        ge_reg  <= ge_next;
        acc_reg <= acc_next;
        top_reg <= top_next;
        hdl_reg <= hdl_next;
        if (accept)
        begin
            op_reg     <= op;
            size_reg   <= req_size;
            handle_reg <= req_handle;
            query_reg  <= query_address;
        end
        if (fin)
        begin
            hres_reg   <= fin_handle;
            sres_reg   <= fin_size;
            status_reg <= fin_status;
            wvalid_reg <= fin_wvalid;
            waddr_reg  <= fin_waddr;
            wdata_reg  <= fin_wdata;
        end
    end

    assign done            = done_reg;
    assign handle_result   = hres_reg;
    assign size_result     = sres_reg;
    assign status          = status_reg;
    assign mem_write_valid = wvalid_reg;
    assign mem_write_addr  = waddr_reg;
    assign mem_write_data  = wdata_reg;

endmodule

>>> tb/hba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hba_checker
// Watches the request, result and register channels of the handle bump
// allocator. It keeps its own copy of the heap registers, bump offset and
// handle table, predicts the result of every accepted request, and compares
// each result strobe field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module hba_checker #(
    parameter int MAX_HANDLES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  op,
    input  logic [31:0] req_size,
    input  logic [31:0] req_handle,
    input  logic [31:0] query_address,
    input  logic        done,
    input  logic [31:0] handle_result,
    input  logic [31:0] size_result,
    input  logic [1:0]  status,
    input  logic        mem_write_valid,
    input  logic [31:0] mem_write_addr,
    input  logic [31:0] mem_write_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output int          pending,
    output int          fails,
    output int          checked
);

    typedef struct packed {
        logic [31:0] handle;
        logic [31:0] size;
        logic [1:0]  status;
        logic        wr_valid;
        logic [31:0] wr_addr;
        logic [31:0] wr_data;
    } hba_result_t;

    logic [31:0] heap_base_r;
    logic [31:0] heap_limit_r;
    logic [31:0] bump_offset;
    int          issued;
    logic        live   [MAX_HANDLES];
    logic [31:0] blk_lo [MAX_HANDLES];
    logic [31:0] blk_hi [MAX_HANDLES];

    hba_result_t expected_results [$];

    task automatic report_failure(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        fails++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_failure($sformatf("%s is %h, expected %h", name, got, want));
    endtask

    // slot index of a live handle, or -1
    function automatic int slot_of_handle(input logic [31:0] h);
        logic [31:0] diff;
        diff = h - heap_base_r;
        if (diff[1:0] != 2'b00)
            return -1;
        if ((diff >> 2) >= 32'(issued))
            return -1;
        if (!live[diff >> 2])
            return -1;
        return int'(diff >> 2);
    endfunction

    task automatic serve_request(input logic [1:0] code, input logic [31:0] nbytes,
                                 input logic [31:0] hnd, input logic [31:0] addr,
                                 output hba_result_t res);
        logic [33:0] top_end;
        int          slot;
        res = '0;
        case (code)
            hba_pkg::OP_ALLOC:
            begin
                top_end = 34'(heap_base_r) + 34'(bump_offset) + 34'(nbytes);
                if (issued >= MAX_HANDLES)
                    res.status = hba_pkg::STATUS_TABLE_FULL;
                else if (top_end > 34'(heap_limit_r))
                    res.status = hba_pkg::STATUS_HEAP_FULL;
                else
                begin
                    live[issued]   = 1'b1;
                    blk_lo[issued] = heap_base_r + bump_offset;
                    blk_hi[issued] = heap_base_r + bump_offset + nbytes;
                    res.handle     = heap_base_r + (32'(issued) << 2);
                    res.wr_valid   = 1'b1;
                    res.wr_addr    = res.handle;
                    res.wr_data    = blk_lo[issued];
                    bump_offset    = bump_offset + nbytes;
                    issued++;
                end
            end
            hba_pkg::OP_DEALLOC:
            begin
                slot = slot_of_handle(hnd);
                if (slot < 0)
                    res.status = hba_pkg::STATUS_UNKNOWN;
                else
                    live[slot] = 1'b0;
            end
            hba_pkg::OP_FIND:
            begin
                res.status = hba_pkg::STATUS_UNKNOWN;
                for (int i = 0; i < issued; i++)
                begin
                    if (live[i] && addr >= blk_lo[i] && addr < blk_hi[i])
                    begin
                        res.handle = heap_base_r + (32'(i) << 2);
                        res.status = hba_pkg::STATUS_OK;
                        break;
                    end
                end
            end
            default:
            begin
                slot = slot_of_handle(hnd);
                if (slot < 0)
                    res.status = hba_pkg::STATUS_UNKNOWN;
                else
                    res.size = blk_hi[slot] - blk_lo[slot];
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hba_result_t got;
        hba_result_t want;
        if (!rst_n)
        begin
            heap_base_r  = '0;
            heap_limit_r = '1;
            bump_offset  = '0;
            issued       = 0;
            fails        = 0;
            checked      = 0;
            foreach (live[i])
                live[i] = 1'b0;
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                got = '{handle_result, size_result, status, mem_write_valid,
                        mem_write_addr, mem_write_data};
                if (expected_results.size() == 0)
                    report_failure($sformatf("result beat with nothing outstanding: %h",
                                             got));
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("handle_result", got.handle, want.handle);
                    compare_field("size_result", got.size, want.size);
                    compare_field("status", 32'(got.status), 32'(want.status));
                    compare_field("mem_write_valid", 32'(got.wr_valid),
                                  32'(want.wr_valid));
                    compare_field("mem_write_addr", got.wr_addr, want.wr_addr);
                    compare_field("mem_write_data", got.wr_data, want.wr_data);
                    checked++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == hba_pkg::CFG_HEAP_BASE)
                    heap_base_r = cfg_data;
                else
                    heap_limit_r = cfg_data;
            end
            if (start && !busy)
            begin
                serve_request(op, req_size, req_handle, query_address, want);
                expected_results.push_back(want);
            end
            pending <= expected_results.size();
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the handle bump allocator: a directed opening over empty table,
// zero size, misaligned and freed handles, exact heap limit and wrapped
// handle addresses, then random request mixes under several heap settings,
// ending with the handle table filled. Checking is done in hba_checker.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SLOTS       = 64;
    localparam int STALL_LIMIT = 5000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        start         = 1'b0;
    logic        busy;
    logic [1:0]  op            = hba_pkg::OP_ALLOC;
    logic [31:0] req_size      = '0;
    logic [31:0] req_handle    = '0;
    logic [31:0] query_address = '0;
    logic        done;
    logic [31:0] handle_result;
    logic [31:0] size_result;
    logic [1:0]  status;
    logic        mem_write_valid;
    logic [31:0] mem_write_addr;
    logic [31:0] mem_write_data;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic        cfg_index     = hba_pkg::CFG_HEAP_BASE;
    logic [31:0] cfg_data      = '0;

    int          pending;
    int          fails;
    int          checked;

    int          quiet_cycles  = 0;
    int          op_count [4]  = '{default: 0};
    int          settings      = 0;
    bit          idle_ok       = 1'b1;
    logic [31:0] cur_base      = '0;
    logic [31:0] block_starts [$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    handle_bump_allocator #(.MAX_HANDLES(SLOTS)) DUT (.*);

    hba_checker #(.MAX_HANDLES(SLOTS)) u_checker (.*);

    // block starts seen so far, used to aim lookups
    always @(posedge clk)
    begin
        if (rst_n && done && mem_write_valid)
            block_starts.push_back(mem_write_data);
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send(input logic [1:0] code, input logic [31:0] nbytes,
                        input logic [31:0] hnd, input logic [31:0] addr);
        if (idle_ok && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        start         <= 1'b1;
        op            <= code;
        req_size      <= nbytes;
        req_handle    <= hnd;
        query_address <= addr;
        do @(posedge clk); while (busy);
        op_count[code]++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0 || busy);
    endtask

    task automatic set_heap(input logic [31:0] base, input logic [31:0] limit);
        cfg_valid <= 1'b1;
        cfg_index <= hba_pkg::CFG_HEAP_BASE;
        cfg_data  <= base;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= hba_pkg::CFG_HEAP_LIMIT;
        cfg_data  <= limit;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_base = base;
        settings++;
    endtask

    // mostly slot-aligned handles, some misaligned, some arbitrary
    function automatic logic [31:0] pick_handle();
        int k;
        k = $urandom_range(0, 19);
        if (k < 15)
            return cur_base + 4 * $urandom_range(0, SLOTS + 2);
        if (k < 18)
            return cur_base + 4 * $urandom_range(0, SLOTS + 2) + $urandom_range(1, 3);
        return $urandom;
    endfunction

    task automatic random_request(input int alloc_pct);
        logic [1:0]  code;
        logic [31:0] nbytes;
        logic [31:0] hnd;
        logic [31:0] addr;
        int          pick;
        int          k;
        nbytes = $urandom;
        hnd    = $urandom;
        addr   = $urandom;
        pick   = $urandom_range(0, 99);
        if (pick < 8)
            code = 2'($urandom);
        else if (pick < 8 + alloc_pct)
        begin
            code = hba_pkg::OP_ALLOC;
            k    = $urandom_range(0, 9);
            if (k < 7)
                nbytes = $urandom_range(0, 64);
            else if (k < 9)
                nbytes = $urandom_range(65, 4096);
        end
        else if (pick < 20 + alloc_pct)
        begin
            code = hba_pkg::OP_DEALLOC;
            hnd  = pick_handle();
        end
        else if (pick < 60 + alloc_pct)
        begin
            code = hba_pkg::OP_FIND;
            if (block_starts.size() > 0 && $urandom_range(0, 7) != 0)
                addr = block_starts[$urandom_range(0, block_starts.size() - 1)]
                       + $urandom_range(0, 300) - 4;
        end
        else
        begin
            code = hba_pkg::OP_SIZE;
            hnd  = pick_handle();
        end
        send(code, nbytes, hnd, addr);
    endtask

    task automatic run_phase(input logic [31:0] base, input logic [31:0] limit,
                             input int count, input int alloc_pct, input bit idling);
        wait_idle();
        set_heap(base, limit);
        idle_ok = idling;
        repeat (count) random_request(alloc_pct);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table
        send(hba_pkg::OP_FIND, $urandom, $urandom, 32'h0);
        send(hba_pkg::OP_SIZE, $urandom, 32'h0, $urandom);
        send(hba_pkg::OP_DEALLOC, $urandom, 32'h0, $urandom);
        // zero size block
        send(hba_pkg::OP_ALLOC, 32'h0, $urandom, $urandom);
        send(hba_pkg::OP_FIND, $urandom, $urandom, 32'h0);
        send(hba_pkg::OP_SIZE, $urandom, 32'h0, $urandom);
        send(hba_pkg::OP_ALLOC, 32'd16, $urandom, $urandom);
        send(hba_pkg::OP_FIND, $urandom, $urandom, 32'd15);
        send(hba_pkg::OP_FIND, $urandom, $urandom, 32'd16);
        send(hba_pkg::OP_SIZE, $urandom, 32'd4, $urandom);
        send(hba_pkg::OP_SIZE, $urandom, 32'd2, $urandom);
        send(hba_pkg::OP_SIZE, $urandom, 32'hFFFF_FFFF, $urandom);
        send(hba_pkg::OP_SIZE, $urandom, 32'd8, $urandom);
        send(hba_pkg::OP_ALLOC, 32'hFFFF_FFFF, $urandom, $urandom);

        // heap limit exactly at the bump pointer plus eight
        wait_idle();
        set_heap(32'h0, 32'd24);
        send(hba_pkg::OP_ALLOC, 32'd9, $urandom, $urandom);
        send(hba_pkg::OP_ALLOC, 32'd8, $urandom, $urandom);
        send(hba_pkg::OP_FIND, $urandom, $urandom, 32'd23);
        send(hba_pkg::OP_FIND, $urandom, $urandom, 32'hFFFF_FFFF);
        send(hba_pkg::OP_DEALLOC, $urandom, 32'd4, $urandom);
        send(hba_pkg::OP_SIZE, $urandom, 32'd4, $urandom);
        send(hba_pkg::OP_FIND, $urandom, $urandom, 32'd15);
        send(hba_pkg::OP_DEALLOC, $urandom, 32'd4, $urandom);

        // handle addresses wrap past the top of the address space
        wait_idle();
        set_heap(32'hFFFF_FFFC, 32'hFFFF_FFFF);
        send(hba_pkg::OP_SIZE, $urandom, 32'd4, $urandom);
        send(hba_pkg::OP_FIND, $urandom, $urandom, 32'd20);
        send(hba_pkg::OP_SIZE, $urandom, 32'd0, $urandom);
        send(hba_pkg::OP_SIZE, $urandom, 32'hFFFF_FFFC, $urandom);
        send(hba_pkg::OP_ALLOC, 32'd1, $urandom, $urandom);

        run_phase(32'h0000_1000, 32'h0010_1000, 130, 8, 1'b1);
        run_phase(32'h0000_0000, 32'h0010_0000, 130, 8, 1'b0);
        run_phase(32'hFFFF_FFF0, 32'hFFFF_FFFF, 70, 10, 1'b1);
        run_phase(32'hFFFF_FFFF, 32'h0000_0000, 50, 10, 1'b1);
        run_phase(32'($urandom_range(0, 16'hFFFF)), 32'h0020_0000, 130, 8, 1'b1);

        // fill the handle table, then keep going against a full table
        wait_idle();
        set_heap(32'h0, 32'hFFFF_FFFF);
        repeat (SLOTS + 2) send(hba_pkg::OP_ALLOC, $urandom_range(0, 32), $urandom, $urandom);
        repeat (20) random_request(12);
        idle_ok = 1'b0;
        repeat (100) random_request(12);

        wait_idle();
        repeat (16) @(posedge clk);

        $display({"summary: %0d requests (%0d allocate, %0d free, %0d lookup, %0d size)",
                  " under %0d heap settings"},
                 op_count[hba_pkg::OP_ALLOC] + op_count[hba_pkg::OP_DEALLOC]
                 + op_count[hba_pkg::OP_FIND] + op_count[hba_pkg::OP_SIZE],
                 op_count[hba_pkg::OP_ALLOC], op_count[hba_pkg::OP_DEALLOC],
                 op_count[hba_pkg::OP_FIND], op_count[hba_pkg::OP_SIZE], settings);
        $display("summary: %0d results compared, %0d blocks handed out, %0d failures",
                 checked, block_starts.size(), fails);
        if (fails == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
